// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the dijet asymmetry selector RTL.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/dasel_pkg.sv =====
// Types and constants for the dijet asymmetry selector.
// Used by the front, queue, back and top-level modules; no dependencies.
package dasel_pkg;

  // Jet count limit and width
  localparam int MAX_JETS    = 512;
  localparam int COUNT_W     = 10;
  localparam int COUNT_LIMIT = (MAX_JETS < 1023) ? MAX_JETS : 1023;

  // Field widths
  localparam int PT_W    = 16;
  localparam int PHI_W   = 15;
  localparam int DPHI_W  = 14;
  localparam int AJ_W    = 17;
  localparam int DEN_W   = 17;

  // Phi constants in Q3.12
  localparam logic signed [16:0] PHI_PI     = 17'sd12868;
  localparam logic signed [16:0] PHI_TWO_PI = 17'sd25736;

  // Event queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MIN_PT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_MIN_PT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DPHI    = 2'd2;

  typedef struct packed {
    logic [PT_W-1:0]   leading_min_pt;
    logic [PT_W-1:0]   subleading_min_pt;
    logic [DPHI_W-1:0] min_delta_phi;
  } cfg_t;

  // Top-two summary of one finished event
  typedef struct packed {
    logic [COUNT_W-1:0]     count;
    logic [PT_W-1:0]        lead_pt;
    logic signed [PHI_W-1:0] lead_phi;
    logic                   lead_valid;
    logic [PT_W-1:0]        sub_pt;
    logic signed [PHI_W-1:0] sub_phi;
    logic                   sub_valid;
  } event_t;

endpackage

// ===== rtl/dijet_asymmetry_selector_core.sv =====
// Dijet asymmetry selector: takes an event's jets as a stream of items and
// gives one result per event with leading/subleading pt, cuts, |dphi| and A_J.
//
// Input channel: in_valid_i / in_stall_o with jet_pt_i, jet_phi_i (Q3.12),
// jet_present_i and last_in_event_i. One item is taken per cycle while
// in_stall_o is low; an item with jet_present_i low updates nothing. The item
// with last_in_event_i high closes the event and sends its summary into a
// two-entry event queue. in_stall_o is high while that queue is full.
// Output channel: out_valid_o / out_stall_i, one result per event, held in an
// output register until taken.
// For each event the back end latches the summary, applies the cuts and
// |dphi|, runs the divide only when A_J is computed, and then raises
// out_valid_o; the divide is a restoring unit producing one quotient bit per
// cycle. The back end handles one event at a time, while jets are taken at
// one per cycle until the queue fills.
// Reset clears the event state, the queue and the output valid, and loads
// the thresholds with 480, 120 and 11260. Write cfg_* only while idle.
module dijet_asymmetry_selector_core
  import dasel_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [PT_W-1:0]         cfg_wdata_i,
  // Jet items
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [PT_W-1:0]         jet_pt_i,
  input  logic signed [PHI_W-1:0] jet_phi_i,
  input  logic                    jet_present_i,
  input  logic                    last_in_event_i,
  // Event results
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COUNT_W-1:0]      jet_count_o,
  output logic                    pt_cuts_pass_o,
  output logic [DPHI_W-1:0]       delta_phi_abs_o,
  output logic                    back_to_back_o,
  output logic [AJ_W-1:0]         asymmetry_o,
  output logic [PT_W-1:0]         leading_pt_o,
  output logic [PT_W-1:0]         subleading_pt_o
);

  cfg_t   cfg_q;
  logic   accept;
  logic   push, pop, full, empty;
  event_t push_data, pop_data;

  // Write threshold registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leading_min_pt    <= 16'd480;
      cfg_q.subleading_min_pt <= 16'd120;
      cfg_q.min_delta_phi     <= 14'd11260;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LEAD_MIN_PT: cfg_q.leading_min_pt    <= cfg_wdata_i;
        CFG_SUB_MIN_PT:  cfg_q.subleading_min_pt <= cfg_wdata_i;
        CFG_MIN_DPHI:    cfg_q.min_delta_phi     <= cfg_wdata_i[DPHI_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold input items while the event queue is full
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  dasel_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .jet_pt_i        (jet_pt_i),
    .jet_phi_i       (jet_phi_i),
    .jet_present_i   (jet_present_i),
    .last_in_event_i (last_in_event_i),
    .push_o          (push),
    .event_o         (push_data)
  );

  dasel_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  dasel_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .event_i         (pop_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .jet_count_o     (jet_count_o),
    .pt_cuts_pass_o  (pt_cuts_pass_o),
    .delta_phi_abs_o (delta_phi_abs_o),
    .back_to_back_o  (back_to_back_o),
    .asymmetry_o     (asymmetry_o),
    .leading_pt_o    (leading_pt_o),
    .subleading_pt_o (subleading_pt_o)
  );

endmodule

// ===== rtl/dasel_front.sv =====
// Front end: accepts jet items and tracks the leading and subleading jet.
// Pushes one event_t summary per event into the queue; uses dasel_pkg.
module dasel_front
  import dasel_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [PT_W-1:0]         jet_pt_i,
  input  logic signed [PHI_W-1:0] jet_phi_i,
  input  logic                    jet_present_i,
  input  logic                    last_in_event_i,
  output logic                    push_o,
  output event_t                  event_o
);

  event_t evt_q, evt_d;

  // Update the top-two selection with the incoming jet
  always_comb begin
    evt_d = evt_q;
    if (jet_present_i) begin
      if (evt_q.count < COUNT_W'(COUNT_LIMIT)) begin
        evt_d.count = evt_q.count + 1'b1;
      end
      if (!evt_q.lead_valid || (jet_pt_i > evt_q.lead_pt)) begin
        evt_d.sub_pt     = evt_q.lead_pt;
        evt_d.sub_phi    = evt_q.lead_phi;
        evt_d.sub_valid  = evt_q.lead_valid;
        evt_d.lead_pt    = jet_pt_i;
        evt_d.lead_phi   = jet_phi_i;
        evt_d.lead_valid = 1'b1;
      end else if (!evt_q.sub_valid || (jet_pt_i > evt_q.sub_pt)) begin
        evt_d.sub_pt    = jet_pt_i;
        evt_d.sub_phi   = jet_phi_i;
        evt_d.sub_valid = 1'b1;
      end
    end
  end

  // Hand the finished event to the queue
  assign push_o  = accept_i && last_in_event_i;
  assign event_o = evt_d;

  // Advance the state; clear it at the end of an event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_q <= '0;
    end else if (accept_i) begin
      if (last_in_event_i) begin
        evt_q <= '0;
      end else begin
        evt_q <= evt_d;
      end
    end
  end

endmodule

// ===== rtl/dasel_fifo.sv =====
// Short queue of finished event summaries between front and back.
// Depth from dasel_pkg::QUEUE_DEPTH; uses assert_macros.svh.
`include "assert_macros.svh"
module dasel_fifo
  import dasel_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t push_data_i,
  input  logic   pop_i,
  output event_t pop_data_o,
  output logic   full_o,
  output logic   empty_o
);

  event_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o, "event queue overflow")
  `ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "event queue underflow")

endmodule

// ===== rtl/dasel_back.sv =====
// Back end: per-event cuts, wrapped delta phi and bit-serial A_J divide.
// Pops event summaries from dasel_fifo; uses dasel_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dasel_back
  import dasel_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               empty_i,
  input  event_t             event_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] jet_count_o,
  output logic               pt_cuts_pass_o,
  output logic [DPHI_W-1:0]  delta_phi_abs_o,
  output logic               back_to_back_o,
  output logic [AJ_W-1:0]    asymmetry_o,
  output logic [PT_W-1:0]    leading_pt_o,
  output logic [PT_W-1:0]    subleading_pt_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;
  localparam int         STEP_W  = $clog2(AJ_W);

  logic [1:0]         state_q;
  event_t             rec_q;
  logic               cuts_q, b2b_q;
  logic [DPHI_W-1:0]  dphi_q;
  logic [DEN_W-1:0]   den_q, rem_q, dvd_lo_q;
  logic [AJ_W-1:0]    quo_q;
  logic [STEP_W-1:0]  step_q;
  logic               out_valid_q;
  logic               out_free;

  // Cut and angle logic on the latched event
  logic                     cuts, b2b;
  logic signed [16:0]       phi_diff, phi_wrap, phi_abs;
  logic [DPHI_W-1:0]        dphi;
  logic [PT_W-1:0]          num;
  logic [DEN_W-1:0]         den;
  logic [32:0]              dividend;

  always_comb begin
    cuts = rec_q.lead_valid && rec_q.sub_valid &&
           (rec_q.lead_pt >= cfg_i.leading_min_pt) &&
           (rec_q.sub_pt >= cfg_i.subleading_min_pt);
    phi_diff = {{2{rec_q.lead_phi[PHI_W-1]}}, rec_q.lead_phi} -
               {{2{rec_q.sub_phi[PHI_W-1]}}, rec_q.sub_phi};
    if (phi_diff > PHI_PI) begin
      phi_wrap = phi_diff - PHI_TWO_PI;
    end else if (phi_diff < -PHI_PI) begin
      phi_wrap = phi_diff + PHI_TWO_PI;
    end else begin
      phi_wrap = phi_diff;
    end
    phi_abs  = phi_wrap[16] ? -phi_wrap : phi_wrap;
    dphi     = cuts ? phi_abs[DPHI_W-1:0] : '0;
    b2b      = cuts && (dphi >= cfg_i.min_delta_phi);
    num      = rec_q.lead_pt - rec_q.sub_pt;
    den      = {1'b0, rec_q.lead_pt} + {1'b0, rec_q.sub_pt};
    dividend = {1'b0, num, 16'b0} + 33'(den >> 1);
  end

  // One restoring divide step: shift in a dividend bit, trial subtract
  logic [DEN_W:0] rem_sh, rem_sub;
  logic           q_bit;

  always_comb begin
    rem_sh  = {rem_q, dvd_lo_q[DEN_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    q_bit   = (rem_sh >= {1'b0, den_q});
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  // Sequence one event: latch, cut, divide when A_J is needed, deliver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          step_q <= '0;
          if (b2b && (den != '0)) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(AJ_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Raise valid on delivery, drop it once the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          rec_q <= event_i;
        end
      end
      ST_CALC: begin
        cuts_q   <= cuts;
        b2b_q    <= b2b;
        dphi_q   <= dphi;
        den_q    <= den;
        rem_q    <= {1'b0, dividend[32:17]};
        dvd_lo_q <= dividend[16:0];
        quo_q    <= '0;
      end
      ST_DIV: begin
        rem_q    <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        dvd_lo_q <= {dvd_lo_q[DEN_W-2:0], 1'b0};
        quo_q    <= {quo_q[AJ_W-2:0], q_bit};
      end
      ST_DONE: begin
        if (out_free) begin
          jet_count_o     <= rec_q.count;
          pt_cuts_pass_o  <= cuts_q;
          delta_phi_abs_o <= dphi_q;
          back_to_back_o  <= b2b_q;
          asymmetry_o     <= quo_q;
          leading_pt_o    <= rec_q.lead_valid ? rec_q.lead_pt : '0;
          subleading_pt_o <= rec_q.sub_valid ? rec_q.sub_pt : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_AT(a_div_den_nonzero, (state_q == ST_DIV) |-> (den_q != '0), "divide by zero")
  `ASSERT_AT(a_rem_below_den, (state_q == ST_DIV) |-> (rem_q < den_q), "remainder not reduced")
  `ASSERT_AT(a_aj_range, (state_q == ST_DONE && out_free) |-> (quo_q <= 17'd65536), "A_J above one")

endmodule

// ===== dv/tb.sv =====
// Testbench for dijet_asymmetry_selector_core: streams jet items, predicts each
// event summary and checks every result. Depends on dasel_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import dasel_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_PCT     = 38;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [COUNT_W-1:0] jet_count;
    logic               cuts;
    logic [DPHI_W-1:0]  dphi;
    logic               b2b;
    logic [AJ_W-1:0]    aj;
    logic [PT_W-1:0]    lead_pt;
    logic [PT_W-1:0]    sub_pt;
  } dijet_summary_t;

  // Tracks the top two jets of the open event and queues expected summaries
  class dijet_summary_model;
    logic [PT_W-1:0]         lead_min_pt;
    logic [PT_W-1:0]         sub_min_pt;
    logic [DPHI_W-1:0]       min_dphi;
    logic [PT_W-1:0]         lead_pt;
    logic [PT_W-1:0]         sub_pt;
    logic signed [PHI_W-1:0] lead_phi;
    logic signed [PHI_W-1:0] sub_phi;
    bit                      lead_seen;
    bit                      sub_seen;
    int unsigned             jets;
    dijet_summary_t          expected_summaries[$];
    int unsigned             mismatches;

    function new();
      lead_min_pt = 16'd480;
      sub_min_pt  = 16'd120;
      min_dphi    = 14'd11260;
      mismatches  = 0;
      clear_event();
    endfunction

    function void clear_event();
      lead_pt   = '0;
      sub_pt    = '0;
      lead_phi  = '0;
      sub_phi   = '0;
      lead_seen = 0;
      sub_seen  = 0;
      jets      = 0;
    endfunction

    // Drop writes to unknown indexes
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PT_W-1:0] data);
      case (idx)
        CFG_LEAD_MIN_PT: lead_min_pt = data;
        CFG_SUB_MIN_PT:  sub_min_pt = data;
        CFG_MIN_DPHI:    min_dphi = data[DPHI_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_summaries.size();
    endfunction

    function void take_jet(logic [PT_W-1:0] pt, logic signed [PHI_W-1:0] phi,
                           bit present, bit last);
      dijet_summary_t s;
      int d;
      longint unsigned num;
      longint unsigned den;
      // Update the top two; a tie with the leader goes to the subleading test
      if (present) begin
        if (jets < COUNT_LIMIT) jets++;
        if (!lead_seen || pt > lead_pt) begin
          sub_pt    = lead_pt;
          sub_phi   = lead_phi;
          sub_seen  = lead_seen;
          lead_pt   = pt;
          lead_phi  = phi;
          lead_seen = 1;
        end else if (!sub_seen || pt > sub_pt) begin
          sub_pt   = pt;
          sub_phi  = phi;
          sub_seen = 1;
        end
      end
      if (!last) return;
      // Close the event
      s = '0;
      s.jet_count = jets[COUNT_W-1:0];
      s.cuts = lead_seen && sub_seen && lead_pt >= lead_min_pt && sub_pt >= sub_min_pt;
      if (s.cuts) begin
        d = int'(lead_phi) - int'(sub_phi);
        if (d > int'(PHI_PI)) d -= int'(PHI_TWO_PI);
        else if (d < -int'(PHI_PI)) d += int'(PHI_TWO_PI);
        if (d < 0) d = -d;
        s.dphi = d[DPHI_W-1:0];
        s.b2b  = s.dphi >= min_dphi;
        if (s.b2b) begin
          num = lead_pt - sub_pt;
          den = lead_pt + sub_pt;
          if (den != 0) s.aj = (num * 65536 + den / 2) / den;
        end
      end
      s.lead_pt = lead_seen ? lead_pt : '0;
      s.sub_pt  = sub_seen ? sub_pt : '0;
      expected_summaries.push_back(s);
      clear_event();
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void compare_summary(dijet_summary_t got);
      dijet_summary_t want;
      if (expected_summaries.size() == 0) begin
        $error("event summary arrived with no event pending");
        mismatches++;
        return;
      end
      want = expected_summaries.pop_front();
      check_field("jet_count", want.jet_count, got.jet_count);
      check_field("pt_cuts_pass", want.cuts, got.cuts);
      check_field("delta_phi_abs", want.dphi, got.dphi);
      check_field("back_to_back", want.b2b, got.b2b);
      check_field("asymmetry", want.aj, got.aj);
      check_field("leading_pt", want.lead_pt, got.lead_pt);
      check_field("subleading_pt", want.sub_pt, got.sub_pt);
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [PT_W-1:0]         cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [PT_W-1:0]         jet_pt_i;
  logic signed [PHI_W-1:0] jet_phi_i;
  logic                    jet_present_i;
  logic                    last_in_event_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [COUNT_W-1:0]      jet_count_o;
  logic                    pt_cuts_pass_o;
  logic [DPHI_W-1:0]       delta_phi_abs_o;
  logic                    back_to_back_o;
  logic [AJ_W-1:0]         asymmetry_o;
  logic [PT_W-1:0]         leading_pt_o;
  logic [PT_W-1:0]         subleading_pt_o;

  dijet_summary_model summary_model;
  bit                 in_idle_en;
  bit                 out_idle_en;
  int unsigned        items_done;
  int unsigned        cycle_count = 0;

  dijet_asymmetry_selector_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .jet_pt_i       (jet_pt_i),
    .jet_phi_i      (jet_phi_i),
    .jet_present_i  (jet_present_i),
    .last_in_event_i(last_in_event_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .jet_count_o    (jet_count_o),
    .pt_cuts_pass_o (pt_cuts_pass_o),
    .delta_phi_abs_o(delta_phi_abs_o),
    .back_to_back_o (back_to_back_o),
    .asymmetry_o    (asymmetry_o),
    .leading_pt_o   (leading_pt_o),
    .subleading_pt_o(subleading_pt_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_stall_i <= out_idle_en && ($urandom_range(99) < IDLE_PCT);
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      summary_model.compare_summary({jet_count_o, pt_cuts_pass_o, delta_phi_abs_o,
                                     back_to_back_o, asymmetry_o, leading_pt_o,
                                     subleading_pt_o});
    end
  end

  // Offer one item and hold it until accepted; starts and ends at a falling edge
  task automatic send_item(logic [PT_W-1:0] pt, logic signed [PHI_W-1:0] phi,
                           bit present, bit last);
    while (in_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    jet_pt_i        <= pt;
    jet_phi_i       <= phi;
    jet_present_i   <= present;
    last_in_event_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    summary_model.take_jet(pt, phi, present, last);
    items_done++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every pending summary is back
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (summary_model.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    summary_model.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Let the block go idle, then load all thresholds plus a spare index
  task automatic drain_and_program(logic [PT_W-1:0] lead_min, logic [PT_W-1:0] sub_min,
                                   logic [PT_W-1:0] dphi_min);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    write_reg(CFG_LEAD_MIN_PT, lead_min);
    write_reg(CFG_SUB_MIN_PT, sub_min);
    write_reg(CFG_MIN_DPHI, dphi_min);
    write_reg(CFG_SPARE, PT_W'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [PT_W-1:0] next_pt(logic [PT_W-1:0] prev);
    case ($urandom_range(9))
      0, 1:    return PT_W'($urandom_range(0, 65535));
      2, 3, 4: return PT_W'($urandom_range(0, 1200));
      5:       return prev;
      6:       return '0;
      7:       return '1;
      default: return PT_W'($urandom_range(80, 700));
    endcase
  endfunction

  // Mostly in range, often nearly opposite the event's random base angle
  function automatic logic signed [PHI_W-1:0] next_phi(logic signed [PHI_W-1:0] base);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'($urandom_range(0, 25736)) - 12868;
      4, 5, 6, 7: begin
        v = int'(base) + 12868 - int'($urandom_range(0, 2000));
        if (v > 12868) v -= 25736;
      end
      8:       v = int'($urandom_range(0, 32767)) - 16384;
      default: v = $urandom_range(1) ? 12868 : -12868;
    endcase
    return v[PHI_W-1:0];
  endfunction

  // One event: a few jets, some ignored items, sometimes an empty closing marker
  task automatic send_random_event();
    int n;
    int r;
    bit empty_tail;
    logic [PT_W-1:0] prev;
    logic signed [PHI_W-1:0] base;
    r = $urandom_range(99);
    if (r < 5) n = 0;
    else if (r < 20) n = 1;
    else if (r < 90) n = $urandom_range(2, 6);
    else n = $urandom_range(7, 20);
    empty_tail = (n == 0) || ($urandom_range(99) < 20);
    base = PHI_W'(int'($urandom_range(0, 25736)) - 12868);
    prev = next_pt('0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8)
        send_item(PT_W'($urandom_range(0, 65535)), PHI_W'($urandom_range(0, 32767)), 0, 0);
      prev = next_pt(prev);
      send_item(prev, next_phi(base), 1, !empty_tail && i == n - 1);
    end
    if (empty_tail)
      send_item(PT_W'($urandom_range(0, 65535)), PHI_W'($urandom_range(0, 32767)), 0, 1);
  endtask

  task automatic random_items(int unsigned n);
    int unsigned target;
    target = items_done + n;
    while (items_done < target) send_random_event();
  endtask

  initial begin
    summary_model   = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    jet_pt_i        = '0;
    jet_phi_i       = '0;
    jet_present_i   = 1'b0;
    last_in_event_i = 1'b0;
    out_stall_i     = 1'b0;
    in_idle_en      = 1'b1;
    out_idle_en     = 1'b1;
    items_done      = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Lone jet, no subleading
    send_item('1, 12868, 1, 1);
    // Empty event closed by a marker
    send_item('0, 0, 0, 1);
    // A jet, an ignored item, a tie with the leader, then an empty closing marker
    send_item(1000, 0, 1, 0);
    send_item('1, -1, 0, 0);
    send_item(1000, -12868, 1, 0);
    send_item(999, 5000, 1, 0);
    send_item('0, 0, 0, 1);
    // Phi at the 15-bit extremes, outside [-pi, pi]
    send_item(2000, 16383, 1, 0);
    send_item(1500, -16384, 1, 1);
    // Subleading one below, then exactly at the thresholds
    send_item(480, 100, 1, 0);
    send_item(119, -12000, 1, 1);
    send_item(480, 100, 1, 0);
    send_item(120, -12000, 1, 1);

    // Zero thresholds: zero pt sum and full-scale asymmetry
    drain_and_program('0, '0, '0);
    send_item('0, 0, 1, 0);
    send_item('0, 0, 1, 1);
    send_item('1, 12868, 1, 0);
    send_item('0, -12868, 1, 1);

    // All-ones thresholds: back-to-back limit above pi
    drain_and_program('1, '1, '1);
    send_item('1, 12868, 1, 0);
    send_item('1, -12868, 1, 1);

    // Random traffic under several threshold settings
    drain_and_program(PT_W'($urandom_range(200, 600)), PT_W'($urandom_range(50, 300)),
                      16'd11260);
    random_items(110);
    wait_results();
    random_items(90);

    // No idling on either side
    drain_and_program(16'd60, 16'd20, 16'd9000);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    random_items(100);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;

    drain_and_program(PT_W'($urandom_range(0, 65535)), PT_W'($urandom_range(0, 65535)),
                      PT_W'($urandom_range(0, 16383)));
    random_items(80);
    drain_and_program(PT_W'($urandom_range(0, 2000)), PT_W'($urandom_range(0, 800)),
                      PT_W'($urandom_range(10000, 12868)));
    random_items(70);

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (summary_model.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
